[sv/gtri_pkg.sv]
// ----------------------------------------------------------------------------
// gtri_pkg
// Shared types, codes and constants of the grid trilinear interpolator.
// ----------------------------------------------------------------------------
package gtri_pkg;

  localparam int SAMPLE_DEPTH_DEFAULT = 4096;
  localparam int FRAC_BITS_DEFAULT    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 8;
  localparam int SIZE_W     = DIM_W + 1;
  localparam int LIN_W      = 3 * DIM_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DIMS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_VLD  = 3'd7;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_VALID = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;

  localparam logic [31:0] ERR_VALUE = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_FIXED,
    JOB_EVAL
  } job_kind_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_SUB,
    F_MUL,
    F_CLS,
    F_ADR1,
    F_ADR2,
    F_ADR3,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } back_state_t;

  function automatic int job_width(input int addr_w, input int frac_bits);
    return 4 + 32 + 4 * addr_w + 3 * (frac_bits + 1);
  endfunction

endpackage

[sv/gtri_front.sv]
// ----------------------------------------------------------------------------
// gtri_front
// Holds the configuration, accepts beats, maps a point to cell corners,
// fractions and store addresses, and queues one job per beat.
// ----------------------------------------------------------------------------
module gtri_front import gtri_pkg::*; #(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEFAULT,
  parameter int FRAC_BITS    = FRAC_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic                        cmd,
  input  logic signed [31:0]          point_x,
  input  logic signed [31:0]          point_y,
  input  logic signed [31:0]          point_z,
  input  logic [11:0]                 sample_index,
  input  logic signed [31:0]          sample_value,
  output logic                        q_push,
  input  logic                        q_full,
  output logic [job_width($clog2(SAMPLE_DEPTH), FRAC_BITS)-1:0] q_data
);

  localparam int AW     = $clog2(SAMPLE_DEPTH);
  localparam int FW     = FRAC_BITS + 1;
  localparam int CIDX_W = 65 - 2 * FRAC_BITS;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
  localparam logic [31:0] DEPTH_32 = 32'(SAMPLE_DEPTH);
  localparam logic [LIN_W-1:0] DEPTH_LIN = LIN_W'(SAMPLE_DEPTH);

  logic signed [31:0] origin [3];
  logic [31:0]        inv [3];
  logic [23:0]        dims;
  logic               gvalid;

  front_state_t state, state_next;

  logic signed [31:0] pnt [3];
  logic [32:0]        mag [3];
  logic               neg [3];
  logic [1:0]         ax;
  logic [64:0]        m_r;
  logic [DIM_W-1:0]   lo [3];
  logic [DIM_W-1:0]   hi [3];
  logic [FW-1:0]      fr [3];
  logic [17:0]        s12;
  logic [16:0]        a1, b1;
  logic [LIN_W-1:0]   a0, b0;

  job_kind_t          j_kind;
  logic [1:0]         j_status;
  logic [AW-1:0]      j_addr, j_dx, j_dy, j_dz;
  logic [31:0]        j_data;

  logic [CIDX_W-1:0]  cidx;
  logic [DIM_W-1:0]   sm1;
  logic [SIZE_W-1:0]  s1, s2;
  logic [LIN_W-1:0]   base, top, diff_x, diff_y, diff_z;
  logic               accept;

  assign accept = push && !full;
  assign q_data = {j_kind, j_status, j_addr, j_data, j_dx, j_dy, j_dz, fr[0], fr[1], fr[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      inv[0]    <= 32'd65536;
      inv[1]    <= 32'd65536;
      inv[2]    <= 32'd65536;
      dims      <= '0;
      gvalid    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:  origin[0] <= cfg_data;
        REG_ORIGIN_Y:  origin[1] <= cfg_data;
        REG_ORIGIN_Z:  origin[2] <= cfg_data;
        REG_INV_X:     inv[0] <= cfg_data;
        REG_INV_Y:     inv[1] <= cfg_data;
        REG_INV_Z:     inv[2] <= cfg_data;
        REG_GRID_DIMS: dims <= cfg_data[23:0];
        REG_GRID_VLD:  gvalid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (push) state_next = (cmd && gvalid) ? F_SUB : F_PUSH;
      end
      F_SUB:  state_next = F_MUL;
      F_MUL:  state_next = F_CLS;
      F_CLS:  state_next = (ax == 2'd2) ? F_ADR1 : F_MUL;
      F_ADR1: state_next = F_ADR2;
      F_ADR2: state_next = F_ADR3;
      F_ADR3: state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != F_IDLE);
    q_push = (state == F_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cidx = m_r[64:2*FRAC_BITS];
    case (ax)
      2'd0:    sm1 = dims[23:16];
      2'd1:    sm1 = dims[15:8];
      default: sm1 = dims[7:0];
    endcase
    s1     = {1'b0, dims[15:8]} + SIZE_W'(1);
    s2     = {1'b0, dims[7:0]} + SIZE_W'(1);
    base   = a0 + LIN_W'(a1) + LIN_W'(lo[2]);
    top    = b0 + LIN_W'(b1) + LIN_W'(hi[2]);
    diff_x = b0 - a0;
    diff_y = LIN_W'(b1) - LIN_W'(a1);
    diff_z = LIN_W'(hi[2]) - LIN_W'(lo[2]);
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          pnt[0] <= point_x;
          pnt[1] <= point_y;
          pnt[2] <= point_z;
          if (!cmd) begin
            if (32'(sample_index) < DEPTH_32) begin
              j_kind   <= JOB_LOAD;
              j_status <= STAT_OK;
            end else begin
              j_kind   <= JOB_FIXED;
              j_status <= STAT_RANGE;
            end
            j_addr <= AW'(32'(sample_index));
            j_data <= (32'(sample_index) < DEPTH_32) ? sample_value : 32'd0;
          end else begin
            j_kind   <= JOB_FIXED;
            j_status <= STAT_NOT_VALID;
            j_data   <= ERR_VALUE;
          end
        end
      end
      F_SUB: begin
        for (int a = 0; a < 3; a++) begin
          logic signed [32:0] t;
          t = {pnt[a][31], pnt[a]} - {origin[a][31], origin[a]};
          neg[a] <= t[32];
          mag[a] <= t[32] ? 33'(-t) : 33'(t);
        end
        ax <= 2'd0;
      end
      F_MUL: m_r <= mag[ax] * inv[ax];
      F_CLS: begin
        if (neg[ax] && m_r != '0) begin
          lo[ax] <= '0;
          hi[ax] <= '0;
          fr[ax] <= '0;
        end else if (cidx > CIDX_W'(sm1)) begin
          lo[ax] <= sm1;
          hi[ax] <= sm1;
          fr[ax] <= ONE;
        end else begin
          lo[ax] <= cidx[DIM_W-1:0];
          hi[ax] <= (cidx[DIM_W-1:0] == sm1) ? sm1 : cidx[DIM_W-1:0] + DIM_W'(1);
          fr[ax] <= {1'b0, m_r[2*FRAC_BITS-1:FRAC_BITS]};
        end
        ax <= ax + 2'd1;
      end
      F_ADR1: begin
        s12 <= s1 * s2;
        a1  <= lo[1] * s2;
        b1  <= hi[1] * s2;
      end
      F_ADR2: begin
        a0 <= lo[0] * s12;
        b0 <= hi[0] * s12;
      end
      F_ADR3: begin
        if (top >= DEPTH_LIN) begin
          j_kind   <= JOB_FIXED;
          j_status <= STAT_RANGE;
          j_data   <= ERR_VALUE;
        end else begin
          j_kind   <= JOB_EVAL;
          j_status <= STAT_OK;
          j_addr   <= base[AW-1:0];
          j_dx     <= diff_x[AW-1:0];
          j_dy     <= diff_y[AW-1:0];
          j_dz     <= diff_z[AW-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/gtri_queue.sv]
// ----------------------------------------------------------------------------
// gtri_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module gtri_queue import gtri_pkg::*; #(
  parameter int WIDTH = job_width($clog2(SAMPLE_DEPTH_DEFAULT), FRAC_BITS_DEFAULT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             q_full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             q_empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wp, rp;
  logic [1:0]       cnt;
  logic             do_wr, do_rd;

  assign q_full  = (cnt == 2'd2);
  assign q_empty = (cnt == 2'd0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = slot[rp];

  always_ff @(posedge clk) begin
    if (do_wr) slot[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= !wp;
      if (do_rd) rp <= !rp;
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

[sv/gtri_back.sv]
// ----------------------------------------------------------------------------
// gtri_back
// Executes queued jobs: writes loads into the sample store, walks the eight
// corners of an evaluation through a weight and accumulate pipeline, and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module gtri_back import gtri_pkg::*; #(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEFAULT,
  parameter int FRAC_BITS    = FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [job_width($clog2(SAMPLE_DEPTH), FRAC_BITS)-1:0] q_data,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  value,
  output logic [1:0]          status
);

  localparam int AW     = $clog2(SAMPLE_DEPTH);
  localparam int FW     = FRAC_BITS + 1;
  localparam int PW     = 2 * FRAC_BITS + 2;
  localparam int PROD_W = 32 + FRAC_BITS + 2;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic [FW-1:0] ONE  = FW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RES_MAX  = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] RES_MIN  = -RES_MAX - ACC_W'(1);

  logic [1:0]    h_kind_bits;
  job_kind_t     h_kind;
  logic [1:0]    h_status;
  logic [AW-1:0] h_addr, h_dx, h_dy, h_dz;
  logic [31:0]   h_data;
  logic [FW-1:0] h_fx, h_fy, h_fz;

  assign {h_kind_bits, h_status, h_addr, h_data, h_dx, h_dy, h_dz, h_fx, h_fy, h_fz} = q_data;
  assign h_kind = job_kind_t'(h_kind_bits);

  logic [31:0] store [SAMPLE_DEPTH];

  back_state_t state, state_next;

  logic [AW-1:0] base, dx, dy, dz, rd_addr;
  logic [FW-1:0] fx, fy, fz, wx_sel, wy_sel, wz_sel;
  logic [3:0]    cnt;
  logic          issue, take;

  logic [31:0]   rd_data;
  logic [PW-1:0] wxy_prod, wt_prod, wxy_full, wt_full;
  logic [FW-1:0] wz1;
  logic signed [31:0] samp2;
  logic signed [PROD_W-1:0] prod3;
  logic signed [ACC_W-1:0]  acc, rnd, shifted;
  logic v1, v2, v3, l1, l2, l3;

  logic          out_valid;
  logic [31:0]   value_r;
  logic [1:0]    status_r;

  assign empty  = !out_valid;
  assign value  = value_r;
  assign status = status_r;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty && !out_valid && h_kind == JOB_EVAL) state_next = B_RUN;
      end
      B_RUN: begin
        if (l3) state_next = B_DONE;
      end
      B_DONE:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    take  = (state == B_IDLE) && !q_empty && !out_valid;
    q_pop = take;
    issue = (state == B_RUN) && !cnt[3];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    rd_addr = base + (cnt[2] ? dx : '0) + (cnt[1] ? dy : '0) + (cnt[0] ? dz : '0);
    wx_sel  = cnt[2] ? fx : ONE - fx;
    wy_sel  = cnt[1] ? fy : ONE - fy;
    wz_sel  = cnt[0] ? fz : ONE - fz;
    wxy_full = wxy_prod + HALF;
    wt_full  = wt_prod + HALF;
    rnd      = acc + HALF_ACC;
    shifted  = rnd >>> FRAC_BITS;
  end

  // sample store, single port
  always_ff @(posedge clk) begin
    if (take && h_kind == JOB_LOAD) store[h_addr] <= h_data;
    if (issue) rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (take && h_kind == JOB_EVAL) begin
      base <= h_addr;
      dx   <= h_dx;
      dy   <= h_dy;
      dz   <= h_dz;
      fx   <= h_fx;
      fy   <= h_fy;
      fz   <= h_fz;
    end
    wxy_prod <= wx_sel * wy_sel;
    wz1      <= wz_sel;
    wt_prod  <= wxy_full[2*FRAC_BITS:FRAC_BITS] * wz1;
    samp2    <= rd_data;
    prod3    <= samp2 * $signed({1'b0, wt_full[2*FRAC_BITS:FRAC_BITS]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      l1  <= 1'b0;
      l2  <= 1'b0;
      l3  <= 1'b0;
    end else begin
      if (take) cnt <= '0;
      else if (issue) cnt <= cnt + 4'd1;
      v1 <= issue;
      l1 <= issue && (cnt[2:0] == 3'd7);
      v2 <= v1;
      l2 <= l1;
      v3 <= v2;
      l3 <= l2;
    end
  end

  always_ff @(posedge clk) begin
    if (take) acc <= '0;
    else if (v3) acc <= acc + ACC_W'(prod3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && h_kind != JOB_EVAL) begin
      out_valid <= 1'b1;
    end else if (state == B_DONE) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && h_kind != JOB_EVAL) begin
      value_r  <= (h_kind == JOB_LOAD) ? 32'd0 : h_data;
      status_r <= h_status;
    end else if (state == B_DONE) begin
      if (shifted > RES_MAX)      value_r <= RES_MAX[31:0];
      else if (shifted < RES_MIN) value_r <= RES_MIN[31:0];
      else                        value_r <= shifted[31:0];
      status_r <= STAT_OK;
    end
  end

endmodule

[sv/grid_trilinear_interpolator.sv]
// ----------------------------------------------------------------------------
// grid_trilinear_interpolator
// Trilinear interpolation over a regular 3-D grid held in a sample store.
// ----------------------------------------------------------------------------
// Input beats enter on push/full: cmd 0 loads sample_value at sample_index,
// cmd 1 evaluates at (point_x, point_y, point_z). Each beat gives exactly one
// result beat on empty/pop with value and status, in order.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// the user is bound to this, as the block itself does not enforce it.
// An evaluate beat keeps full high while the three axis scalings share one
// 33x32 multiplier in turn (F_MUL, then F_CLS, for each axis), and then the
// address steps F_ADR1, F_ADR2 and F_ADR3 run. The back reads the eight
// corners from the single-port store one per cycle behind a four-stage weight
// pipeline. The front takes no new beat until its job is pushed into the queue,
// but it can work on the next beat while the back still runs the previous job.
// A two-entry job queue sits between front and back; the back takes no new
// job while a result waits to be taken.
// When pop stays low the queue fills and full rises.
// Reset restores the register defaults and empties queue and result; the
// sample store keeps its contents, so entries must be loaded before use.
// ----------------------------------------------------------------------------
module grid_trilinear_interpolator import gtri_pkg::*; #(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEFAULT,
  parameter int FRAC_BITS    = FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic                  cmd,
  input  logic signed [31:0]    point_x,
  input  logic signed [31:0]    point_y,
  input  logic signed [31:0]    point_z,
  input  logic [11:0]           sample_index,
  input  logic signed [31:0]    sample_value,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [31:0]    value,
  output logic [1:0]            status
);

  localparam int JOB_W = job_width($clog2(SAMPLE_DEPTH), FRAC_BITS);

  logic             q_push, q_full, q_pop, q_empty;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  gtri_front #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_data       (q_wdata)
  );

  gtri_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (q_rdata),
    .q_empty (q_empty)
  );

  gtri_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_rdata),
    .empty   (empty),
    .pop     (pop),
    .value   (value),
    .status  (status)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("front pushed a job into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("back popped an empty queue");

  a_not_valid_value: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == STAT_NOT_VALID) |-> value == ERR_VALUE)
    else $error("grid-not-valid result without error value");

  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not idle after reset");

endmodule
